@@ hdl/sobel_gradient_direction_top_assert.svh @@
// Assertion helpers shared by the queue, front and back RTL files of the gradient block.
`ifndef SOBEL_GRADIENT_DIRECTION_TOP_ASSERT_SVH
`define SOBEL_GRADIENT_DIRECTION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SGD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SGD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sgd_pkg.sv @@
`timescale 1ns / 1ps

package sgd_pkg;

  // Default row store depth.
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  // Field and register widths.
  localparam int unsigned IMG_W_W  = 11;
  localparam int unsigned IMG_H_W  = 13;
  localparam int unsigned ROW_W    = 14;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned MAG_W    = 8;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned GRAD_W   = 11;
  localparam int unsigned ABS_W    = 10;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd480;
  localparam logic [SUM_W-1:0]   MAG_MAX   = 11'd255;

  // Register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Input action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Direction codes.
  typedef enum logic [DIR_W-1:0] {
    DIR_VERT = 2'd0,
    DIR_HORZ = 2'd1,
    DIR_SAME = 2'd2,
    DIR_OPP  = 2'd3
  } sgd_dir_e;

  // Per-step control that the front hands to the back.
  typedef struct packed {
    logic       row_ge1;
    logic       row_ge2;
    logic       has_res;
    logic       last;
    logic [2:0] rmask;
    logic [2:0] cmask;
  } sgd_flags_t;

endpackage

@@ hdl/sgd_ram.sv @@
`timescale 1ns / 1ps

module sgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port and one registered read port; a read sees the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/sgd_fifo.sv @@
`timescale 1ns / 1ps
`include "sobel_gradient_direction_top_assert.svh"

module sgd_fifo import sgd_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] data_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = data_q[rd_ptr_q];

  `SGD_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `SGD_ASSERT_IMP(a_no_pop_when_empty, clk_i, rst_ni, pop_i, valid_o, "pop from empty queue")

endmodule

@@ hdl/sgd_front.sv @@
`timescale 1ns / 1ps
`include "sobel_gradient_direction_top_assert.svh"

module sgd_front import sgd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_i,
  input  logic [IMG_H_W-1:0]               h_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [PIX_W-1:0]                 pixel_i,
  input  logic                             full_i,
  output logic                             push_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     push_col_o,
  output logic [PIX_W-1:0]                 push_bot_o,
  output sgd_flags_t                       push_flags_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned LAG_W = $clog2(MAX_WIDTH + 2);

  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [LAG_W-1:0] lag_q, lag_d;

  logic             accept;
  logic             frame_in;
  logic             step;
  logic [COL_W:0]   w_ext;
  logic [ROW_W-1:0] h_ext;
  logic [LAG_W-1:0] w_plus1;
  logic [COL_W:0]   in_col_inc;
  logic [COL_W:0]   out_col_inc;
  logic [ROW_W-1:0] out_row_inc;
  logic             in_col_wrap;
  logic             out_col_wrap;
  sgd_flags_t       flags;

  assign w_ext   = (COL_W + 1)'(w_i);
  assign h_ext   = ROW_W'(h_i);
  assign w_plus1 = LAG_W'(w_i) + LAG_W'(1);

  // Accept while the queue has room; an early drain is taken and dropped.
  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign frame_in   = (in_row_q >= h_ext);
  assign step       = accept && !((action_i == ACT_DRAIN) && !frame_in);

  assign in_col_inc   = {1'b0, in_col_q} + (COL_W + 1)'(1);
  assign out_col_inc  = {1'b0, out_col_q} + (COL_W + 1)'(1);
  assign out_row_inc  = out_row_q + ROW_W'(1);
  assign in_col_wrap  = (in_col_inc >= w_ext);
  assign out_col_wrap = (out_col_inc >= w_ext);

  // Classification of the step: result or not, border masks, frame end.
  always_comb begin
    flags          = '0;
    flags.row_ge1  = (in_row_q != '0);
    flags.row_ge2  = (in_row_q >= ROW_W'(2));
    flags.has_res  = (lag_q >= w_plus1);
    flags.last     = out_col_wrap && (out_row_inc >= h_ext);
    flags.rmask[0] = (out_row_q != '0) && (out_row_q <= h_ext);
    flags.rmask[1] = (out_row_q < h_ext);
    flags.rmask[2] = (out_row_inc < h_ext);
    flags.cmask[0] = (out_col_q != '0) && ({1'b0, out_col_q} <= w_ext);
    flags.cmask[1] = ({1'b0, out_col_q} < w_ext);
    flags.cmask[2] = (out_col_inc < w_ext);
  end

  // Position and lag updates.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    if (step) begin
      if (in_col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
      if (!flags.has_res) begin
        lag_d = lag_q + LAG_W'(1);
      end else if (flags.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        lag_d     = '0;
      end else if (out_col_wrap) begin
        out_col_d = '0;
        out_row_d = out_row_inc;
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
    end
  end

  // Queue entry; a pixel past the frame end counts as a zero pixel.
  assign push_o       = step;
  assign push_col_o   = in_col_q;
  assign push_bot_o   = frame_in ? '0 : pixel_i;
  assign push_flags_o = flags;

  `SGD_ASSERT_NXT(a_frame_rewinds, clk_i, rst_ni, push_o && push_flags_o.has_res && push_flags_o.last,
                  in_col_q == '0 && in_row_q == '0 && lag_q == '0, "frame end left stale position")

endmodule

@@ hdl/sgd_back.sv @@
`timescale 1ns / 1ps
`include "sobel_gradient_direction_top_assert.svh"

module sgd_back import sgd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col_i,
  input  logic [PIX_W-1:0]             q_bot_i,
  input  sgd_flags_t                   q_flags_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [MAG_W-1:0]             magnitude_o,
  output logic [DIR_W-1:0]             direction_o,
  output logic                         last_of_frame_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // Row store stage.
  logic              b1_valid_q, b1_valid_d;
  logic [COL_W-1:0]  b1_col_q;
  logic [PIX_W-1:0]  b1_bot_q;
  sgd_flags_t        b1_flags_q;
  logic              fwd_q;
  logic [PIX_W-1:0]  fwd_up_q, fwd_mid_q;
  logic [PIX_W-1:0]  ram_up_rd, ram_mid_rd;
  logic [PIX_W-1:0]  up_raw, mid_raw;
  logic [PIX_W-1:0]  top_px, mid_px;

  // Window and gradient stage.
  logic [PIX_W-1:0]  win_q [3][3];
  logic [PIX_W-1:0]  nwin  [3][3];
  logic signed [GRAD_W-1:0] px [3][3];
  logic signed [GRAD_W-1:0] gx, gy;
  logic              b2_valid_q, b2_valid_d;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic              b2_last_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [MAG_W-1:0]  mag_q;
  sgd_dir_e          dir_q;
  logic              last_q;
  logic [ABS_W-1:0]  abs_x, abs_y;
  logic [SUM_W-1:0]  sum;
  logic [MAG_W-1:0]  mag;
  sgd_dir_e          dir;

  logic out_ready, b2_go, b2_ready, b1_go, b1_ready;

  // Stage handshakes: a step without a result leaves after the row store stage.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign b2_go     = b2_valid_q && out_ready;
  assign b2_ready  = !b2_valid_q || out_ready;
  assign b1_go     = b1_valid_q && (!b1_flags_q.has_res || b2_ready);
  assign b1_ready  = !b1_valid_q || b1_go;
  assign pop_o     = q_valid_i && b1_ready;

  // Row stores: read on transfer from the queue, written back as the step leaves.
  sgd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk_i     (clk_i),
    .wr_en_i   (b1_go),
    .wr_addr_i (b1_col_q),
    .wr_data_i (mid_raw),
    .rd_en_i   (pop_o),
    .rd_addr_i (q_col_i),
    .rd_data_o (ram_up_rd)
  );

  sgd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
    .clk_i     (clk_i),
    .wr_en_i   (b1_go),
    .wr_addr_i (b1_col_q),
    .wr_data_i (b1_bot_q),
    .rd_en_i   (pop_o),
    .rd_addr_i (q_col_i),
    .rd_data_o (ram_mid_rd)
  );

  // A read at the column being written in the same cycle takes the new data.
  assign up_raw  = fwd_q ? fwd_up_q : ram_up_rd;
  assign mid_raw = fwd_q ? fwd_mid_q : ram_mid_rd;
  assign top_px  = b1_flags_q.row_ge2 ? up_raw : '0;
  assign mid_px  = b1_flags_q.row_ge1 ? mid_raw : '0;

  always_comb begin
    b1_valid_d = b1_valid_q;
    if (pop_o) begin
      b1_valid_d = 1'b1;
    end else if (b1_go) begin
      b1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      b1_valid_q <= b1_valid_d;
      if (pop_o) begin
        fwd_q <= b1_go && (b1_col_q == q_col_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_col_q   <= q_col_i;
      b1_bot_q   <= q_bot_i;
      b1_flags_q <= q_flags_i;
      fwd_up_q   <= mid_raw;
      fwd_mid_q  <= b1_bot_q;
    end
  end

  // Window after the shift, masked at the frame border.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nwin[r][0] = win_q[r][1];
      nwin[r][1] = win_q[r][2];
    end
    nwin[0][2] = top_px;
    nwin[1][2] = mid_px;
    nwin[2][2] = b1_bot_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px[r][c] = (b1_flags_q.rmask[r] && b1_flags_q.cmask[c])
                 ? $signed({{(GRAD_W - PIX_W){1'b0}}, nwin[r][c]}) : '0;
      end
    end
  end

  // Sobel kernels.
  assign gx = (px[0][2] + (px[1][2] <<< 1) + px[2][2])
            - (px[0][0] + (px[1][0] <<< 1) + px[2][0]);
  assign gy = (px[2][0] + (px[2][1] <<< 1) + px[2][2])
            - (px[0][0] + (px[0][1] <<< 1) + px[0][2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (b1_go) begin
      win_q <= nwin;
    end
  end

  always_comb begin
    b2_valid_d = b2_valid_q;
    if (b1_go && b1_flags_q.has_res) begin
      b2_valid_d = 1'b1;
    end else if (b2_go) begin
      b2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else begin
      b2_valid_q <= b2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_go && b1_flags_q.has_res) begin
      gx_q      <= gx;
      gy_q      <= gy;
      b2_last_q <= b1_flags_q.last;
    end
  end

  // Magnitude with saturation, and the direction code.
  assign abs_x = gx_q[GRAD_W-1] ? ABS_W'(-gx_q) : ABS_W'(gx_q);
  assign abs_y = gy_q[GRAD_W-1] ? ABS_W'(-gy_q) : ABS_W'(gy_q);
  assign sum   = SUM_W'(abs_x) + SUM_W'(abs_y);
  assign mag   = (sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : sum[MAG_W-1:0];

  always_comb begin
    if (gy_q == '0) begin
      dir = DIR_VERT;
    end else if (gx_q == '0) begin
      dir = DIR_HORZ;
    end else if (gx_q[GRAD_W-1] == gy_q[GRAD_W-1]) begin
      dir = DIR_SAME;
    end else begin
      dir = DIR_OPP;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (b2_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_go) begin
      mag_q  <= mag;
      dir_q  <= dir;
      last_q <= b2_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign direction_o     = dir_q;
  assign last_of_frame_o = last_q;

  `SGD_ASSERT_IMP(a_flat_is_vertical, clk_i, rst_ni, out_valid_q && mag_q == '0,
                  dir_q == DIR_VERT, "zero magnitude with nonzero direction")
  `SGD_ASSERT_IMP(a_fwd_same_column, clk_i, rst_ni, pop_o && b1_go && b1_col_q == q_col_i,
                  b1_valid_q, "forward without a step in the row store stage")

endmodule

@@ hdl/sobel_gradient_direction_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// pixel in  input      in_valid_i / in_stall_o  action_i, pixel_i
// result    output     out_valid_o / out_stall_i magnitude_o, direction_o, last_of_frame_o
// config    APB slave  psel, penable, pwrite    paddr, pwdata, prdata (pready tied high)
//
// One pixel or drain transfer per cycle while in_stall_o is low; the result for a pixel leaves
// width+1 steps later, through queue, row store, gradient and output register.
// Both row stores are single-port-write RAMs read once per step: one step a cycle unless stalled.
// Reset clears positions, window and valid bits; row store contents are not cleared.
// A stalled output fills the output register, the gradient and row store stages and the
// two-entry queue, then stalls the input.

module sobel_gradient_direction_top import sgd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [PIX_W-1:0]  pixel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MAG_W-1:0]  magnitude_o,
  output logic [DIR_W-1:0]  direction_o,
  output logic              last_of_frame_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (WID_W > IMG_W_W) ? WID_W : IMG_W_W;
  localparam int unsigned ITEM_W = COL_W + PIX_W + $bits(sgd_flags_t);

  logic [IMG_W_W-1:0] img_w_q, img_w_d;
  logic [IMG_H_W-1:0] img_h_q, img_h_d;
  logic               cfg_wr;
  logic               reg_idx;
  logic [CMP_W-1:0]   w_ext;
  logic [WID_W-1:0]   eff_w;
  logic [IMG_H_W-1:0] eff_h;

  logic               q_full, q_push, q_pop, q_valid;
  logic [COL_W-1:0]   push_col, q_col;
  logic [PIX_W-1:0]   push_bot, q_bot;
  sgd_flags_t         push_flags, q_flags;
  logic [ITEM_W-1:0]  q_din, q_dout;

  // Configuration registers behind the APB port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    img_w_d = img_w_q;
    img_h_d = img_h_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  img_w_d = pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: img_h_d = pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_W_RST;
      img_h_q <= IMG_H_RST;
    end else begin
      img_w_q <= img_w_d;
      img_h_q <= img_h_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(img_w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(img_h_q);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, width limited to the store depth.
  always_comb begin
    w_ext = CMP_W'(img_w_q);
    if (w_ext == '0) begin
      w_ext = CMP_W'(1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_ext = CMP_W'(MAX_WIDTH);
    end
  end

  assign eff_w = w_ext[WID_W-1:0];
  assign eff_h = (img_h_q == '0) ? IMG_H_W'(1) : img_h_q;

  sgd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .w_i          (eff_w),
    .h_i          (eff_h),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .pixel_i      (pixel_i),
    .full_i       (q_full),
    .push_o       (q_push),
    .push_col_o   (push_col),
    .push_bot_o   (push_bot),
    .push_flags_o (push_flags)
  );

  // Step queue between classification and the datapath.
  assign q_din = {push_col, push_bot, push_flags};
  assign {q_col, q_bot, q_flags} = q_dout;

  sgd_fifo #(.DATA_W(ITEM_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  sgd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_col_i         (q_col),
    .q_bot_i         (q_bot),
    .q_flags_i       (q_flags),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .magnitude_o     (magnitude_o),
    .direction_o     (direction_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule
